// ----- hdl/drmt_pkg.sv -----
`timescale 1ns / 1ps

package drmt_pkg;

  localparam int DEF_TABLE_SLOTS = 16;
  localparam int DEF_COORD_BITS  = 16;

  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int ECOUNT_W = 5;
  localparam int DROP_W   = 16;
  localparam int HEIGHT_W = 15;
  localparam int SPAN_W   = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SPAN_W;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 15'd1024;
  localparam logic [SPAN_W-1:0]   SPAN_RESET   = 17'd256;
  localparam logic [DROP_W-1:0]   DROP_MAX     = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_MERGED   = 3'd0,
    STAT_APPENDED = 3'd1,
    STAT_DROPPED  = 3'd2,
    STAT_IGNORED  = 3'd3,
    STAT_CLEARED  = 3'd4,
    STAT_READ_OK  = 3'd5,
    STAT_UNUSED   = 3'd6
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORLD_HEIGHT = 1'b0,
    REG_MAX_SPAN     = 1'b1
  } reg_idx_t;

endpackage

// ----- hdl/drmt_box_store.sv -----
`timescale 1ns / 1ps

module drmt_box_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/drmt_merge_unit.sv -----
`timescale 1ns / 1ps

// Box layout: {max_y, max_x, min_y, min_x}, each COORD_BITS signed.
module drmt_merge_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic [4*COORD_BITS-1:0] a,
  input  logic [4*COORD_BITS-1:0] b,
  output logic                    touch,
  output logic [4*COORD_BITS-1:0] uni
);

  localparam int C = COORD_BITS;
  localparam logic signed [C:0] ONE_E = {{C{1'b0}}, 1'b1};

  logic signed [C-1:0] ax0, ay0, ax1, ay1;
  logic signed [C-1:0] bx0, by0, bx1, by1;
  logic                t;

  // lo lies more than one cell past hi
  function automatic logic gap(input logic signed [C-1:0] lo, input logic signed [C-1:0] hi);
    logic signed [C:0] lo_e;
    logic signed [C:0] hi_e;
    lo_e = {lo[C-1], lo};
    hi_e = {hi[C-1], hi};
    return lo_e > (hi_e + ONE_E);
  endfunction

  function automatic logic [C-1:0] smin(input logic signed [C-1:0] p,
                                        input logic signed [C-1:0] q);
    return (p < q) ? p : q;
  endfunction

  function automatic logic [C-1:0] smax(input logic signed [C-1:0] p,
                                        input logic signed [C-1:0] q);
    return (p > q) ? p : q;
  endfunction

  assign ax0 = $signed(a[C-1:0]);
  assign ay0 = $signed(a[2*C-1:C]);
  assign ax1 = $signed(a[3*C-1:2*C]);
  assign ay1 = $signed(a[4*C-1:3*C]);
  assign bx0 = $signed(b[C-1:0]);
  assign by0 = $signed(b[2*C-1:C]);
  assign bx1 = $signed(b[3*C-1:2*C]);
  assign by1 = $signed(b[4*C-1:3*C]);

  assign t = !(gap(ax0, bx1) || gap(bx0, ax1) || gap(ay0, by1) || gap(by0, ay1));

  always_ff @(posedge clk) begin
    touch <= t;
    uni   <= {smax(ay1, by1), smax(ax1, bx1), smin(ay0, by0), smin(ax0, bx0)};
  end

endmodule

// ----- hdl/damage_region_merge_table.sv -----
`timescale 1ns / 1ps

// Damage box table. A request is taken when start is high and busy is low; its
// single result appears for exactly one cycle with done high and cannot be held
// off. Clear, unknown kinds and reads of an unused slot answer in the cycle after
// the request; a read of a stored slot first passes through S_READ. A record clips
// the box in S_CLIP, compares stored entries in turn through S_SCAN_W and S_SCAN
// while looking for a match, then compares the later entries, last first, through
// S_ABS_W and S_ABS while the grown entry absorbs them, moving the last entry into
// an absorbed slot in S_MOVE where needed, and writes back in S_FIN or places the
// box in S_PLACE; its result shows in the cycle after that. Each comparison waits
// on the registered read of the box memory followed by the registered compare/union
// unit, shared by every comparison. busy falls in the cycle that done is shown, so
// the next request can follow at once. Write the configuration only while idle; a
// write during a record changes the clip and span limits in the middle of its scan.
module damage_region_merge_table #(
  parameter int TABLE_SLOTS = drmt_pkg::DEF_TABLE_SLOTS,
  parameter int COORD_BITS  = drmt_pkg::DEF_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [drmt_pkg::KIND_W-1:0]         kind,
  input  logic signed [COORD_BITS-1:0]        box_min_x,
  input  logic signed [COORD_BITS-1:0]        box_min_y,
  input  logic signed [COORD_BITS-1:0]        box_max_x,
  input  logic signed [COORD_BITS-1:0]        box_max_y,
  input  logic [drmt_pkg::SLOT_W-1:0]         read_slot,
  input  logic                                wr_en,
  input  logic [drmt_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [drmt_pkg::CFG_DATA_W-1:0]     wr_data,
  output logic                                done,
  output logic [drmt_pkg::STATUS_W-1:0]       status,
  output logic [drmt_pkg::ECOUNT_W-1:0]       entry_count,
  output logic [drmt_pkg::DROP_W-1:0]         dropped_count,
  output logic signed [COORD_BITS-1:0]        out_min_x,
  output logic signed [COORD_BITS-1:0]        out_min_y,
  output logic signed [COORD_BITS-1:0]        out_max_x,
  output logic signed [COORD_BITS-1:0]        out_max_y
);

  import drmt_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int BOX_W  = 4 * C;
  localparam int IDX_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam int XW     = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
  localparam int HW     = ((C > HEIGHT_W) ? C : HEIGHT_W) + 2;
  localparam int SPW    = ((C > SPAN_W) ? C : SPAN_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLIP,
    S_SCAN_W,
    S_SCAN,
    S_PLACE,
    S_ABS_W,
    S_ABS,
    S_MOVE,
    S_FIN,
    S_READ
  } state_t;

  state_t                state, state_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [IDX_W-1:0]      slot_i, slot_i_next;
  logic [IDX_W-1:0]      slot_k, slot_k_next;
  logic [BOX_W-1:0]      cur, cur_next;
  logic [DROP_W-1:0]     drop_total, drop_next;
  logic [HEIGHT_W-1:0]   world_height;
  logic [SPAN_W-1:0]     max_span;
  logic                  done_next;
  logic [STATUS_W-1:0]   status_next;
  logic [BOX_W-1:0]      out_box, out_next;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [BOX_W-1:0]      mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [BOX_W-1:0]      rd_data;

  logic                  touch;
  logic [BOX_W-1:0]      uni;

  logic signed [C-1:0]   cx0, cy0, cx1, cy1;
  logic signed [C-1:0]   ry0, ry1;
  logic signed [HW-1:0]  top_e, y1_e;
  logic                  empty;
  logic signed [C:0]     dx, dy;
  logic                  hit;
  logic [IDX_W-1:0]      last_slot;
  logic [IDX_W-1:0]      k_dec;
  logic [XW-1:0]         slot_x;
  logic                  slot_ok;

  drmt_box_store #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH (BOX_W),
    .ADDR_W(IDX_W)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(rd_data)
  );

  drmt_merge_unit #(
    .COORD_BITS(C)
  ) u_merge (
    .clk  (clk),
    .a    (cur),
    .b    (rd_data),
    .touch(touch),
    .uni  (uni)
  );

  // row clipping of the raw box held in cur
  assign cx0   = $signed(cur[C-1:0]);
  assign cy0   = $signed(cur[2*C-1:C]);
  assign cx1   = $signed(cur[3*C-1:2*C]);
  assign cy1   = $signed(cur[4*C-1:3*C]);
  assign top_e = $signed(HW'(world_height)) - $signed(HW'(1));
  assign y1_e  = HW'(cy1);
  assign ry1   = (y1_e > top_e) ? $signed(top_e[C-1:0]) : cy1;
  assign ry0   = cy0[C-1] ? '0 : cy0;
  assign empty = (cx1 < cx0) || (cy1 < cy0) || (ry0 > ry1);

  // span check on the registered union
  assign dx  = $signed({uni[3*C-1], uni[3*C-1:2*C]}) - $signed({uni[C-1], uni[C-1:0]});
  assign dy  = $signed({uni[4*C-1], uni[4*C-1:3*C]}) - $signed({uni[2*C-1], uni[2*C-1:C]});
  assign hit = touch && (SPW'(dx[C-1:0]) < SPW'(max_span))
                     && (SPW'(dy[C-1:0]) < SPW'(max_span));

  assign last_slot = IDX_W'(count - CNT_W'(1));
  assign k_dec     = slot_k - IDX_W'(1);
  assign slot_x    = XW'(read_slot);
  assign slot_ok   = slot_x < XW'(count);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    count_next  = count;
    slot_i_next = slot_i;
    slot_k_next = slot_k;
    cur_next    = cur;
    drop_next   = drop_total;
    done_next   = 1'b0;
    status_next = STAT_IGNORED;
    out_next    = '0;
    mem_we      = 1'b0;
    mem_waddr   = count[IDX_W-1:0];
    mem_wdata   = cur;
    mem_raddr   = slot_i;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (kind)
            KIND_RECORD: begin
              cur_next   = {box_max_y, box_max_x, box_min_y, box_min_x};
              state_next = S_CLIP;
            end
            KIND_CLEAR: begin
              count_next  = '0;
              done_next   = 1'b1;
              status_next = STAT_CLEARED;
            end
            KIND_READ: begin
              if (slot_ok) begin
                mem_raddr  = slot_x[IDX_W-1:0];
                state_next = S_READ;
              end else begin
                done_next   = 1'b1;
                status_next = STAT_UNUSED;
              end
            end
            default: begin
              done_next   = 1'b1;
              status_next = STAT_IGNORED;
            end
          endcase
        end
      end
      S_CLIP: begin
        cur_next = {cy1 == ry1 ? cy1 : ry1, cx1, ry0, cx0};
        if (empty) begin
          done_next   = 1'b1;
          status_next = STAT_IGNORED;
          state_next  = S_IDLE;
        end else if (count == '0) begin
          state_next = S_PLACE;
        end else begin
          slot_i_next = '0;
          mem_raddr   = '0;
          state_next  = S_SCAN_W;
        end
      end
      S_SCAN_W: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          cur_next = uni;
          if (last_slot != slot_i) begin
            slot_k_next = last_slot;
            mem_raddr   = last_slot;
            state_next  = S_ABS_W;
          end else begin
            state_next = S_FIN;
          end
        end else if ((CNT_W'(slot_i) + CNT_W'(1)) < count) begin
          slot_i_next = slot_i + IDX_W'(1);
          mem_raddr   = slot_i + IDX_W'(1);
          state_next  = S_SCAN_W;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        if (count == CNT_W'(TABLE_SLOTS)) begin
          if (drop_total != DROP_MAX) begin
            drop_next = drop_total + DROP_W'(1);
          end
          status_next = STAT_DROPPED;
        end else begin
          mem_we      = 1'b1;
          count_next  = count + CNT_W'(1);
          status_next = STAT_APPENDED;
        end
      end
      S_ABS_W: begin
        state_next = S_ABS;
      end
      S_ABS: begin
        if (hit && (slot_k != last_slot)) begin
          // fetch the last entry to refill this slot
          cur_next   = uni;
          mem_raddr  = last_slot;
          state_next = S_MOVE;
        end else begin
          if (hit) begin
            cur_next   = uni;
            count_next = count - CNT_W'(1);
          end
          if (k_dec != slot_i) begin
            slot_k_next = k_dec;
            mem_raddr   = k_dec;
            state_next  = S_ABS_W;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_MOVE: begin
        mem_we     = 1'b1;
        mem_waddr  = slot_k;
        mem_wdata  = rd_data;
        count_next = count - CNT_W'(1);
        if (k_dec != slot_i) begin
          slot_k_next = k_dec;
          mem_raddr   = k_dec;
          state_next  = S_ABS_W;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        mem_we      = 1'b1;
        mem_waddr   = slot_i;
        done_next   = 1'b1;
        status_next = STAT_MERGED;
        state_next  = S_IDLE;
      end
      S_READ: begin
        out_next    = rd_data;
        done_next   = 1'b1;
        status_next = STAT_READ_OK;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      drop_total   <= '0;
      done         <= 1'b0;
      world_height <= HEIGHT_RESET;
      max_span     <= SPAN_RESET;
    end else begin
      state      <= state_next;
      count      <= count_next;
      drop_total <= drop_next;
      done       <= done_next;
      if (wr_en) begin
        unique case (reg_idx_t'(wr_index))
          REG_WORLD_HEIGHT: world_height <= wr_data[HEIGHT_W-1:0];
          REG_MAX_SPAN:     max_span     <= wr_data[SPAN_W-1:0];
        endcase
      end
    end
    slot_i <= slot_i_next;
    slot_k <= slot_k_next;
    cur    <= cur_next;
    if (done_next) begin
      status        <= status_next;
      entry_count   <= ECOUNT_W'(count_next);
      dropped_count <= drop_next;
      out_box       <= out_next;
    end
  end

  assign out_min_x = $signed(out_box[C-1:0]);
  assign out_min_y = $signed(out_box[2*C-1:C]);
  assign out_max_x = $signed(out_box[3*C-1:2*C]);
  assign out_max_y = $signed(out_box[4*C-1:3*C]);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_SLOTS))
    else $error("entry count beyond table size");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request neither started nor answered");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still working");

  a_drop_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (drop_total >= $past(drop_total)))
    else $error("drop counter went backward");

  a_absorb_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_ABS) |-> (slot_k > slot_i))
    else $error("absorb scan reached the merged entry");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import drmt_pkg::*;

  localparam int SLOTS     = DEF_TABLE_SLOTS;
  localparam int COORD_W   = DEF_COORD_BITS;
  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -COORD_MAX - 1;
  localparam int SETTLE    = 4;
  localparam int LATENCY   = 70;
  localparam int PER_PHASE = 205;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] max_y;
    logic [SLOT_W-1:0]         slot;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic [ECOUNT_W-1:0]       count;
    logic [DROP_W-1:0]         dropped;
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] hi_y;
  } answer_t;

  typedef struct {
    longint x0;
    longint y0;
    longint x1;
    longint y1;
  } box_t;

  // Tracks the box table, the drop counter and both registers; queues one answer
  // per accepted request and compares shown results against them in order.
  class box_table_model;
    box_t    boxes[SLOTS];
    int      used;
    int      refused;
    longint  rows;
    longint  span;
    answer_t owed[$];
    int      errors;
    int      checked;
    int      by_status[8];

    function new();
      used = 0;
      refused = 0;
      rows = HEIGHT_RESET;
      span = SPAN_RESET;
      errors = 0;
      checked = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_WORLD_HEIGHT) rows = val[HEIGHT_W-1:0];
      else span = val[SPAN_W-1:0];
    endfunction

    // Adjacent or overlapping within one cell, and the union fits the span.
    function bit touches(box_t a, box_t b);
      longint wide;
      longint tall;
      if (a.x0 > b.x1 + 1 || b.x0 > a.x1 + 1 || a.y0 > b.y1 + 1 || b.y0 > a.y1 + 1)
        return 1'b0;
      wide = (a.x1 > b.x1 ? a.x1 : b.x1) - (a.x0 < b.x0 ? a.x0 : b.x0) + 1;
      tall = (a.y1 > b.y1 ? a.y1 : b.y1) - (a.y0 < b.y0 ? a.y0 : b.y0) + 1;
      return wide <= span && tall <= span;
    endfunction

    function box_t unite(box_t a, box_t b);
      box_t u;
      u.x0 = a.x0 < b.x0 ? a.x0 : b.x0;
      u.y0 = a.y0 < b.y0 ? a.y0 : b.y0;
      u.x1 = a.x1 > b.x1 ? a.x1 : b.x1;
      u.y1 = a.y1 > b.y1 ? a.y1 : b.y1;
      return u;
    endfunction

    function status_t merge_box(request_t rq);
      box_t   r;
      longint top;
      int     i;
      int     k;
      top = rows - 1;
      r.x0 = rq.min_x;
      r.y0 = rq.min_y;
      r.x1 = rq.max_x;
      r.y1 = rq.max_y;
      if (r.x1 < r.x0 || r.y1 < r.y0) return STAT_IGNORED;
      if (r.y0 < 0) r.y0 = 0;
      if (r.y1 > top) r.y1 = top;
      if (r.y0 > r.y1) return STAT_IGNORED;
      for (i = 0; i < used; i++) begin
        if (!touches(boxes[i], r)) continue;
        boxes[i] = unite(boxes[i], r);
        // sweep the grown entry over later ones, last first; fill holes from the end
        for (k = used - 1; k > i; k--) begin
          if (!touches(boxes[i], boxes[k])) continue;
          boxes[i] = unite(boxes[i], boxes[k]);
          boxes[k] = boxes[used - 1];
          used--;
        end
        return STAT_MERGED;
      end
      if (used >= SLOTS) begin
        if (refused < DROP_MAX) refused++;
        return STAT_DROPPED;
      end
      boxes[used] = r;
      used++;
      return STAT_APPENDED;
    endfunction

    function void note_request(request_t rq);
      answer_t a;
      a.lo_x = '0;
      a.lo_y = '0;
      a.hi_x = '0;
      a.hi_y = '0;
      case (rq.kind)
        KIND_RECORD: a.status = merge_box(rq);
        KIND_CLEAR: begin
          used = 0;
          a.status = STAT_CLEARED;
        end
        KIND_READ: begin
          if (rq.slot < used) begin
            a.lo_x = COORD_W'(boxes[rq.slot].x0);
            a.lo_y = COORD_W'(boxes[rq.slot].y0);
            a.hi_x = COORD_W'(boxes[rq.slot].x1);
            a.hi_y = COORD_W'(boxes[rq.slot].y1);
            a.status = STAT_READ_OK;
          end else begin
            a.status = STAT_UNUSED;
          end
        end
        default: a.status = STAT_IGNORED;
      endcase
      a.count = ECOUNT_W'(used);
      a.dropped = DROP_W'(refused);
      by_status[a.status]++;
      owed.push_back(a);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      if (errors <= 50)
        $display("tb: mismatch in %s at result %0d: got %0d, want %0d", what, checked, got,
                 want);
    endtask

    task check_result(answer_t got);
      answer_t want;
      if (owed.size() == 0) begin
        report("result with no request waiting", got.status, 0);
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.count !== want.count) report("entry_count", got.count, want.count);
      if (got.dropped !== want.dropped) report("dropped_count", got.dropped, want.dropped);
      if (got.lo_x !== want.lo_x) report("out_min_x", got.lo_x, want.lo_x);
      if (got.lo_y !== want.lo_y) report("out_min_y", got.lo_y, want.lo_y);
      if (got.hi_x !== want.hi_x) report("out_max_x", got.hi_x, want.hi_x);
      if (got.hi_y !== want.hi_y) report("out_max_y", got.hi_y, want.hi_y);
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [KIND_W-1:0]         kind = '0;
  logic signed [COORD_W-1:0] box_min_x = '0;
  logic signed [COORD_W-1:0] box_min_y = '0;
  logic signed [COORD_W-1:0] box_max_x = '0;
  logic signed [COORD_W-1:0] box_max_y = '0;
  logic [SLOT_W-1:0]         read_slot = '0;
  logic                      wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      wr_index = '0;
  logic [CFG_DATA_W-1:0]     wr_data = '0;
  logic                      done;
  logic [STATUS_W-1:0]       status;
  logic [ECOUNT_W-1:0]       entry_count;
  logic [DROP_W-1:0]         dropped_count;
  logic signed [COORD_W-1:0] out_min_x;
  logic signed [COORD_W-1:0] out_min_y;
  logic signed [COORD_W-1:0] out_max_x;
  logic signed [COORD_W-1:0] out_max_y;

  box_table_model board = new();
  answer_t        shown;
  int             settings = 0;

  damage_region_merge_table DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .box_min_x     (box_min_x),
    .box_min_y     (box_min_y),
    .box_max_x     (box_max_x),
    .box_max_y     (box_max_y),
    .read_slot     (read_slot),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .done          (done),
    .status        (status),
    .entry_count   (entry_count),
    .dropped_count (dropped_count),
    .out_min_x     (out_min_x),
    .out_min_y     (out_min_y),
    .out_max_x     (out_max_x),
    .out_max_y     (out_max_y)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      shown.status  = status;
      shown.count   = entry_count;
      shown.dropped = dropped_count;
      shown.lo_x    = out_min_x;
      shown.lo_y    = out_min_y;
      shown.hi_x    = out_max_x;
      shown.hi_y    = out_max_y;
      board.check_result(shown);
    end
  end

  function automatic logic signed [COORD_W-1:0] clip_coord(int v);
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return COORD_W'(v);
  endfunction

  function automatic request_t box_req(int x0, int y0, int x1, int y1);
    request_t rq;
    rq.kind  = KIND_RECORD;
    rq.min_x = COORD_W'(x0);
    rq.min_y = COORD_W'(y0);
    rq.max_x = COORD_W'(x1);
    rq.max_y = COORD_W'(y1);
    rq.slot  = '0;
    return rq;
  endfunction

  function automatic request_t op_req(logic [KIND_W-1:0] k, int s);
    request_t rq;
    rq = box_req(0, 0, 0, 0);
    rq.kind = k;
    rq.slot = SLOT_W'(s);
    return rq;
  endfunction

  // Mostly boxes clustered near cx (merges), some scattered (appends, then drops
  // once full), some with raw random corners; reads, rare clears, odd kinds.
  function automatic request_t random_req(int rows, int span, int cx);
    request_t rq;
    int       pick;
    int       sz;
    int       x0;
    int       y0;
    int       ylim;
    rq.kind  = KIND_RECORD;
    rq.min_x = COORD_W'($urandom);
    rq.min_y = COORD_W'($urandom);
    rq.max_x = COORD_W'($urandom);
    rq.max_y = COORD_W'($urandom);
    rq.slot  = SLOT_W'($urandom);
    sz = span < 2 ? 2 : (span > 4000 ? 4000 : span);
    pick = $urandom_range(0, 99);
    if (pick < 1) begin
      rq.kind = KIND_CLEAR;
    end else if (pick < 22) begin
      rq.kind = KIND_READ;
    end else if (pick < 24) begin
      rq.kind = KIND_UNKNOWN;
    end else if (pick < 36) begin
      // keep the raw corners
    end else if (pick < 58) begin
      x0 = int'($urandom_range(0, 65535)) + COORD_MIN;
      y0 = $urandom_range(0, rows);
      rq.min_x = clip_coord(x0);
      rq.max_x = clip_coord(x0 + int'($urandom_range(0, 6)));
      rq.min_y = clip_coord(y0);
      rq.max_y = clip_coord(y0 + int'($urandom_range(0, 6)));
    end else begin
      ylim = rows < 2 * sz ? rows : 2 * sz;
      x0 = cx + int'($urandom_range(0, 2 * sz));
      y0 = int'($urandom_range(0, ylim + 3)) - 3;
      rq.min_x = clip_coord(x0);
      rq.max_x = clip_coord(x0 + int'($urandom_range(0, sz / 2)));
      rq.min_y = clip_coord(y0);
      rq.max_y = clip_coord(y0 + int'($urandom_range(0, sz / 2)));
    end
    return rq;
  endfunction

  // Start stays high on return; the caller either issues the next request in the
  // same step or drops start.
  task automatic issue(request_t rq, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    kind      <= rq.kind;
    box_min_x <= rq.min_x;
    box_min_y <= rq.min_y;
    box_max_x <= rq.max_x;
    box_max_y <= rq.max_y;
    read_slot <= rq.slot;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_request(rq);
  endtask

  task automatic apply_config(int rows, int span);
    start <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= REG_WORLD_HEIGHT;
    wr_data  <= CFG_DATA_W'(rows);
    @(posedge clk);
    board.set_reg(REG_WORLD_HEIGHT, CFG_DATA_W'(rows));
    wr_index <= REG_MAX_SPAN;
    wr_data  <= CFG_DATA_W'(span);
    @(posedge clk);
    board.set_reg(REG_MAX_SPAN, CFG_DATA_W'(span));
    wr_en <= 1'b0;
    settings++;
  endtask

  initial begin
    int p;
    int n;
    int rows;
    int span;
    int idle;
    int gap;
    int calm;
    int cx;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values
    issue(op_req(KIND_READ, 0), 0);
    issue(op_req(KIND_UNKNOWN, 5), 0);
    issue(box_req(5, 0, 4, 9), 0);
    issue(box_req(0, -20, 9, -5), 0);
    issue(box_req(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX), 0);
    issue(box_req(10, 10, 20, 20), 0);
    issue(box_req(21, 10, 30, 20), 0);
    issue(box_req(40, 40, 50, 50), 0);
    issue(box_req(60, 60, 70, 70), 0);
    // joins the box at 10..30 and pulls in the two boxes above it
    issue(box_req(31, 21, 59, 59), 0);
    issue(op_req(KIND_READ, 1), 0);
    issue(op_req(KIND_READ, 15), 0);
    issue(op_req(KIND_CLEAR, 0), 0);

    // no rows at all: every box comes out empty
    apply_config(0, SPAN_RESET);
    issue(box_req(0, 0, 5, 5), 0);

    // zero span: identical boxes still cannot merge
    apply_config(1, 0);
    issue(box_req(0, -10, 3, 10), 0);
    issue(box_req(0, -10, 3, 10), 0);

    apply_config(COORD_MAX, 1 << COORD_W);
    issue(box_req(COORD_MIN, 0, -1, COORD_MAX), 0);
    issue(box_req(0, 0, COORD_MAX, 100), 0);
    issue(op_req(KIND_READ, 2), 0);

    // single cells: only the same cell merges
    apply_config(1, 1);
    issue(box_req(7, 0, 7, 0), 0);
    issue(box_req(7, 0, 7, 0), 0);
    issue(box_req(8, 0, 8, 0), 0);

    calm = 0;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin rows = HEIGHT_RESET; span = SPAN_RESET; idle = 0; end
        1: begin rows = COORD_MAX; span = 1 << COORD_W; idle = 70; end
        2: begin rows = 1; span = 1; idle = 36; end
        3: begin rows = 200; span = 40; idle = 0; end
        4: begin
          rows = $urandom_range(1, COORD_MAX);
          span = $urandom_range(1, 1 << COORD_W);
          idle = 70;
        end
        default: begin rows = 300; span = 2; idle = 36; end
      endcase
      apply_config(rows, span);
      cx = int'($urandom_range(0, 65535)) + COORD_MIN;
      for (n = 0; n < PER_PHASE; n++) begin
        gap = 0;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 99) < 4) calm = $urandom_range(10, 30);
        else if ($urandom_range(0, 99) < idle) gap = $urandom_range(1, 40);
        issue(random_req(rows, span, cx), gap);
      end
    end

    start <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);

    $display("tb: %0d results checked under %0d register settings, %0d errors",
             board.checked, settings, board.errors);
    $display("tb: merged %0d appended %0d dropped %0d ignored %0d cleared %0d read %0d unused %0d",
             board.by_status[STAT_MERGED], board.by_status[STAT_APPENDED],
             board.by_status[STAT_DROPPED], board.by_status[STAT_IGNORED],
             board.by_status[STAT_CLEARED], board.by_status[STAT_READ_OK],
             board.by_status[STAT_UNUSED]);
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("tb: timeout");
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/drmt_pkg.sv
hdl/drmt_box_store.sv
hdl/drmt_merge_unit.sv
hdl/damage_region_merge_table.sv
verif/tb.sv
